/* rtl/core/arrive_steering_follower_assert.svh */
// assertion macros for the arrive steering follower
`ifndef ARRIVE_STEERING_FOLLOWER_ASSERT_SVH
`define ARRIVE_STEERING_FOLLOWER_ASSERT_SVH
`ifndef SYNTH
`define ASF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asf assertion failed");
`define ASF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asf assertion failed");
`else
`define ASF_ASSERT_IMP(label, ante, cons)
`define ASF_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/asf_pkg.sv */
// shared types and constants of the arrive steering follower
package asf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SPEED_W    = 24;
  localparam int DECEL_W    = 16;
  localparam int OFFSET_W   = 24;
  localparam int VEL_W      = 32;
  localparam int DT_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECELERATION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z     = 3'd4;

  localparam logic [SPEED_W-1:0]         MAX_SPEED_RST = 24'd153600;
  localparam logic [DECEL_W-1:0]         DECEL_RST     = 16'd768;
  localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST  = -24'sd12800;
  localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST  = 24'sd7680;
  localparam logic signed [OFFSET_W-1:0] OFFSET_Z_RST  = 24'sd51200;

  // force * 2 / 5 is the velocity gain: 2|force| times ceil(2^36 / 5), then >> 36
  // exact floor for 2|force| below 2^34
  localparam logic [33:0] GAIN_RECIP = 34'd13743895348;
  localparam int          GAIN_SHIFT = 36;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } asf_op_t;

  typedef struct packed {
    logic    start;
    asf_op_t op;
  } asf_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIST,
    ST_SPD,
    ST_DMUL,
    ST_DDIV,
    ST_ACC,
    ST_VSQ,
    ST_MSQ,
    ST_NORM,
    ST_TMUL,
    ST_TDIV,
    ST_STEP,
    ST_OUT
  } asf_state_t;

endpackage

/* rtl/core/asf_in_if.sv */
// input channel of the arrive steering follower
interface asf_in_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  logic signed [COORD_WIDTH-1:0] target_z;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic [15:0]                   step_time;

  modport source (output valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
                  step_time, input ready);
  modport sink (input valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
                step_time, output ready);
endinterface

/* rtl/core/asf_out_if.sv */
// result channel of the arrive steering follower
interface asf_out_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_x;
  logic signed [COORD_WIDTH-1:0] new_y;
  logic signed [COORD_WIDTH-1:0] new_z;
  logic signed [COORD_WIDTH-1:0] speed_x;
  logic signed [COORD_WIDTH-1:0] speed_y;
  logic signed [COORD_WIDTH-1:0] speed_z;

  modport source (output valid, new_x, new_y, new_z, speed_x, speed_y, speed_z,
                  input ready);
  modport sink (input valid, new_x, new_y, new_z, speed_x, speed_y, speed_z,
                output ready);
endinterface

/* rtl/core/asf_iter_unit.sv */
// shared bit-serial multiply, divide and square root unit
module asf_iter_unit import asf_pkg::*; #(
  parameter int WORD_WIDTH = 70
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  asf_ctl_t              ctl,
  input  logic [WORD_WIDTH-1:0] opa,
  input  logic [WORD_WIDTH-1:0] opb,
  input  logic [WORD_WIDTH-1:0] opc,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] res
);

  localparam int WW   = WORD_WIDTH;
  localparam int CNTW = $clog2(WW + 1);

  logic            busy_r;
  asf_op_t         op_r;
  logic [CNTW-1:0] cnt_r;
  logic [WW-1:0]   acc_r;
  logic [WW-1:0]   x_r;
  logic [WW-1:0]   y_r;

  logic [WW-1:0] rem_sh;
  logic [WW-1:0] trial;
  logic [WW-1:0] add_a;
  logic [WW-1:0] add_b;
  logic          sub;
  logic [WW:0]   sum;
  logic          no_borrow;

  always_comb begin
    rem_sh = {acc_r[WW-2:0], x_r[WW-1]};
    trial  = x_r | y_r;
    unique case (op_r)
      OP_DIV: begin
        add_a = rem_sh;
        add_b = y_r;
        sub   = 1'b1;
      end
      OP_SQRT: begin
        add_a = acc_r;
        add_b = trial;
        sub   = 1'b1;
      end
      default: begin
        add_a = acc_r;
        add_b = x_r;
        sub   = 1'b0;
      end
    endcase
    // one adder serves all three operations
    sum       = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (WW + 1)'(sub);
    no_borrow = sum[WW];
    done      = busy_r && ((op_r == OP_MUL) ? (y_r == '0) : (cnt_r == '0));
    res       = (op_r == OP_MUL) ? acc_r : x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      if (!busy_r && ctl.start) begin
        busy_r <= 1'b1;
        op_r   <= ctl.op;
        cnt_r  <= (ctl.op == OP_SQRT) ? CNTW'(WW / 2) : CNTW'(WW);
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && ctl.start) begin
      unique case (ctl.op)
        OP_DIV: begin
          acc_r <= '0;
          x_r   <= opa;
          y_r   <= opb;
        end
        OP_SQRT: begin
          acc_r <= opa;
          x_r   <= '0;
          y_r   <= WW'(1) << (WW - 2);
        end
        default: begin
          acc_r <= opc;
          x_r   <= opa;
          y_r   <= opb;
        end
      endcase
    end else if (busy_r && !done) begin
      unique case (op_r)
        OP_DIV: begin
          acc_r <= no_borrow ? sum[WW-1:0] : rem_sh;
          x_r   <= {x_r[WW-2:0], no_borrow};
        end
        OP_SQRT: begin
          if (no_borrow) begin
            acc_r <= sum[WW-1:0];
            x_r   <= (x_r >> 1) | y_r;
          end else begin
            x_r <= x_r >> 1;
          end
          y_r <= y_r >> 2;
        end
        default: begin
          if (y_r[0]) begin
            acc_r <= sum[WW-1:0];
          end
          x_r <= x_r << 1;
          y_r <= y_r >> 1;
        end
      endcase
    end
  end

endmodule

/* rtl/core/arrive_steering_follower.sv */
// arrive steering follower top level: sequencer, state and config registers
// Usage:
//   in_ch carries one tick per beat: target and current position (Q.8) and the
//   tick length step_time (Q0.16 s). out_ch returns one beat per tick with the
//   saturated new position and the new velocity. The cfg_ port writes max
//   speed, deceleration and the aim offsets; the user must use it only while
//   the block idles, as the block does not enforce this. Every multiply, divide
//   and square root runs on one shared bit-serial unit under the sequencer
//   below, one operation at a time. The velocity gain of 2/5 is a multiply by
//   a fixed 34-bit reciprocal. A tick skips the steering steps when the aim
//   point is reached and the cap steps when the speed needs no cap.
//   in_ch.ready is high only while the block is idle; a new tick is taken the
//   cycle after the previous result beat leaves.
//   The result is held on out_ch until the receiver takes it; nothing is lost
//   while the receiver stalls.
//   Reset clears the stored velocity to zero and loads the register defaults.
module arrive_steering_follower import asf_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  asf_in_if.sink                in_ch,
  asf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "arrive_steering_follower_assert.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = ((CW > OFFSET_W) ? CW : OFFSET_W) + 2;
  localparam int WW  = 2 * DW + 2;
  localparam int NPW = ((CW > 26) ? CW : 26) + 1;
  localparam int FW  = 34;

  asf_state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       last;

  logic [SPEED_W-1:0]         ms_r;
  logic [DECEL_W-1:0]         dec_r;
  logic signed [OFFSET_W-1:0] off_r [3];
  logic signed [VEL_W-1:0]    vel_r [3];

  logic signed [DW-1:0] d_r   [3];
  logic signed [CW-1:0] pos_r [3];
  logic signed [CW-1:0] np_r  [3];
  logic [DT_W-1:0]      dt_r;
  logic [WW-1:0]        sum_r;
  logic [WW-1:0]        dist_r;
  logic [WW-1:0]        tmp_r;
  logic [SPEED_W-1:0]   speed_r;
  logic                 fneg_r;

  logic signed [CW-1:0] tgt [3];
  logic signed [CW-1:0] psn [3];
  logic [DW-1:0]        dmag;
  logic [VEL_W-1:0]     vmag;
  logic                 in_acc;
  logic                 out_acc;

  asf_ctl_t      eng_ctl;
  logic [WW-1:0] eng_a;
  logic [WW-1:0] eng_b;
  logic [WW-1:0] eng_c;
  logic          eng_done;
  logic [WW-1:0] eng_res;

  logic signed [FW-1:0]  des_s;
  logic signed [FW-1:0]  force_s;
  logic [FW-1:0]         fmag;
  logic [24:0]           smag;
  logic signed [NPW-1:0] step_s;
  logic signed [NPW-1:0] np;
  logic [NPW-CW:0]       np_top;
  logic signed [CW-1:0]  np_sat;

  asf_iter_unit #(.WORD_WIDTH(WW)) u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (eng_ctl),
    .opa  (eng_a),
    .opb  (eng_b),
    .opc  (eng_c),
    .done (eng_done),
    .res  (eng_res)
  );

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign last    = (idx_r == 2'd2);

  always_comb begin
    tgt[0] = in_ch.target_x;
    tgt[1] = in_ch.target_y;
    tgt[2] = in_ch.target_z;
    psn[0] = in_ch.pos_x;
    psn[1] = in_ch.pos_y;
    psn[2] = in_ch.pos_z;
    dmag   = d_r[idx_r][DW-1] ? DW'(-d_r[idx_r]) : DW'(d_r[idx_r]);
    vmag   = vel_r[idx_r][VEL_W-1] ? VEL_W'(-vel_r[idx_r]) : VEL_W'(vel_r[idx_r]);

    // desired component carries the sign of the distance component
    des_s   = d_r[idx_r][DW-1] ? -FW'(eng_res[SPEED_W-1:0]) : FW'(eng_res[SPEED_W-1:0]);
    force_s = des_s - FW'(vel_r[idx_r]);
    fmag    = force_s[FW-1] ? FW'(-force_s) : FW'(force_s);

    smag   = eng_res[40:16];
    step_s = vel_r[idx_r][VEL_W-1] ? -NPW'(smag) : NPW'(smag);
    np     = NPW'(pos_r[idx_r]) + step_s;
    np_top = np[NPW-1:CW-1];
    if ((&np_top) || !(|np_top)) begin
      np_sat = np[CW-1:0];
    end else begin
      np_sat = np[NPW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SQ;
      ST_SQ: begin
        if (eng_done) begin
          idx_nxt = last ? 2'd0 : idx_r + 2'd1;
          if (last) state_nxt = (eng_res == '0) ? ST_VSQ : ST_DIST;
        end
      end
      ST_DIST: if (eng_done) state_nxt = ST_SPD;
      ST_SPD:  if (eng_done) state_nxt = ST_DMUL;
      ST_DMUL: if (eng_done) state_nxt = ST_DDIV;
      ST_DDIV: if (eng_done) state_nxt = ST_ACC;
      ST_ACC: begin
        if (eng_done) begin
          idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
          state_nxt = last ? ST_VSQ : ST_DMUL;
        end
      end
      ST_VSQ: begin
        if (eng_done) begin
          idx_nxt = last ? 2'd0 : idx_r + 2'd1;
          if (last) state_nxt = ST_MSQ;
        end
      end
      ST_MSQ:  if (eng_done) state_nxt = (sum_r > eng_res) ? ST_NORM : ST_STEP;
      ST_NORM: if (eng_done) state_nxt = ST_TMUL;
      ST_TMUL: if (eng_done) state_nxt = ST_TDIV;
      ST_TDIV: begin
        if (eng_done) begin
          idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
          state_nxt = last ? ST_STEP : ST_TMUL;
        end
      end
      ST_STEP: begin
        if (eng_done) begin
          idx_nxt = last ? 2'd0 : idx_r + 2'd1;
          if (last) state_nxt = ST_OUT;
        end
      end
      ST_OUT:  if (out_acc) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    eng_ctl.start = 1'b0;
    eng_ctl.op    = OP_MUL;
    eng_a         = '0;
    eng_b         = '0;
    eng_c         = '0;
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SQ: begin
        eng_ctl.start = 1'b1;
        eng_a         = WW'(dmag);
        eng_b         = WW'(dmag);
        eng_c         = (idx_r == 2'd0) ? '0 : sum_r;
      end
      ST_DIST, ST_NORM: begin
        eng_ctl.start = 1'b1;
        eng_ctl.op    = OP_SQRT;
        eng_a         = sum_r;
      end
      ST_SPD: begin
        eng_ctl.start = 1'b1;
        eng_ctl.op    = OP_DIV;
        eng_a         = dist_r << 8;
        eng_b         = WW'(dec_r);
      end
      ST_DMUL: begin
        eng_ctl.start = 1'b1;
        eng_a         = WW'(dmag);
        eng_b         = WW'(speed_r);
      end
      ST_DDIV, ST_TDIV: begin
        eng_ctl.start = 1'b1;
        eng_ctl.op    = OP_DIV;
        eng_a         = tmp_r;
        eng_b         = dist_r;
      end
      ST_ACC: begin
        eng_ctl.start = 1'b1;
        eng_a         = tmp_r;
        eng_b         = WW'(GAIN_RECIP);
      end
      ST_VSQ: begin
        eng_ctl.start = 1'b1;
        eng_a         = WW'(vmag);
        eng_b         = WW'(vmag);
        eng_c         = (idx_r == 2'd0) ? '0 : sum_r;
      end
      ST_MSQ: begin
        eng_ctl.start = 1'b1;
        eng_a         = WW'(ms_r);
        eng_b         = WW'(ms_r);
      end
      ST_TMUL: begin
        eng_ctl.start = 1'b1;
        eng_a         = WW'(vmag);
        eng_b         = WW'(ms_r);
      end
      ST_STEP: begin
        eng_ctl.start = 1'b1;
        eng_a         = WW'(vmag);
        eng_b         = WW'(dt_r);
      end
      ST_OUT:  out_ch.valid = 1'b1;
      default: in_ch.ready = 1'b0;
    endcase
  end

  always_comb begin
    out_ch.new_x   = np_r[0];
    out_ch.new_y   = np_r[1];
    out_ch.new_z   = np_r[2];
    out_ch.speed_x = CW'(vel_r[0]);
    out_ch.speed_y = CW'(vel_r[1]);
    out_ch.speed_z = CW'(vel_r[2]);
  end

  // control state, velocity and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= 2'd0;
      ms_r     <= MAX_SPEED_RST;
      dec_r    <= DECEL_RST;
      off_r[0] <= OFFSET_X_RST;
      off_r[1] <= OFFSET_Y_RST;
      off_r[2] <= OFFSET_Z_RST;
      vel_r[0] <= '0;
      vel_r[1] <= '0;
      vel_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MAX_SPEED:    ms_r     <= cfg_wdata[SPEED_W-1:0];
          REG_DECELERATION: dec_r    <= cfg_wdata[DECEL_W-1:0];
          REG_OFFSET_X:     off_r[0] <= cfg_wdata[OFFSET_W-1:0];
          REG_OFFSET_Y:     off_r[1] <= cfg_wdata[OFFSET_W-1:0];
          REG_OFFSET_Z:     off_r[2] <= cfg_wdata[OFFSET_W-1:0];
          default:          ;
        endcase
      end
      if (eng_done && state_r == ST_ACC) begin
        vel_r[idx_r] <= fneg_r ? vel_r[idx_r] - eng_res[GAIN_SHIFT +: VEL_W]
                               : vel_r[idx_r] + eng_res[GAIN_SHIFT +: VEL_W];
      end
      if (eng_done && state_r == ST_TDIV) begin
        vel_r[idx_r] <= vel_r[idx_r][VEL_W-1] ? -eng_res[VEL_W-1:0]
                                              : eng_res[VEL_W-1:0];
      end
    end
  end

  // working registers of the current tick
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= DW'(tgt[i]) + DW'(off_r[i]) - DW'(psn[i]);
        pos_r[i] <= psn[i];
      end
      dt_r <= in_ch.step_time;
    end
    if (eng_done) begin
      unique case (state_r)
        ST_SQ, ST_VSQ:    sum_r  <= eng_res;
        ST_DIST, ST_NORM: dist_r <= eng_res;
        ST_SPD: begin
          // zero deceleration or a fast quotient both fall back to max speed
          if (dec_r == '0 || eng_res > WW'(ms_r)) begin
            speed_r <= ms_r;
          end else begin
            speed_r <= eng_res[SPEED_W-1:0];
          end
        end
        ST_DMUL, ST_TMUL: tmp_r <= eng_res;
        ST_DDIV: begin
          tmp_r  <= WW'(fmag) << 1;
          fneg_r <= force_s[FW-1];
        end
        ST_STEP: np_r[idx_r] <= np_sat;
        default: ;
      endcase
    end
  end

  `ASF_ASSERT_IMP(a_ready_not_with_result, in_ch.ready, !out_ch.valid)
  `ASF_ASSERT_IMP(a_done_only_when_busy, eng_done, state_r != ST_IDLE && state_r != ST_OUT)
  `ASF_ASSERT_NXT(a_idle_after_result, out_acc, in_ch.ready)
  `ASF_ASSERT_IMP(a_dist_nonzero_sum, state_r == ST_DIST, sum_r != '0)

endmodule

/* bench/tb_top.sv */
// testbench for the arrive steering follower: scoreboard, stimulus and checking
`timescale 1ns / 100ps

module tb_top import asf_pkg::*; ();

  localparam int CW = 32;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES = 6000;

  typedef struct {
    logic signed [CW-1:0] tx, ty, tz, px, py, pz;
    logic [DT_W-1:0]      dt;
  } tick_t;

  typedef struct {
    logic signed [CW-1:0] nx, ny, nz, sx, sy, sz;
  } motion_t;

  class steer_scoreboard;
    logic [SPEED_W-1:0]         max_speed;
    logic [DECEL_W-1:0]         decel;
    logic signed [OFFSET_W-1:0] offs[3];
    logic signed [VEL_W-1:0]    vel[3];
    motion_t                    pending[$];
    int                         mismatches;

    function new();
      max_speed = MAX_SPEED_RST;
      decel = DECEL_RST;
      offs[0] = OFFSET_X_RST;
      offs[1] = OFFSET_Y_RST;
      offs[2] = OFFSET_Z_RST;
      foreach (vel[i]) vel[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MAX_SPEED:    max_speed = val;
        REG_DECELERATION: decel = val[DECEL_W-1:0];
        REG_OFFSET_X:     offs[0] = val;
        REG_OFFSET_Y:     offs[1] = val;
        REG_OFFSET_Z:     offs[2] = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function logic [63:0] root(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        sq = {64'd0, c} * {64'd0, c};
        if (sq <= n) r = c;
      end
      return r;
    endfunction

    function logic [63:0] scale(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
      return p[63:0];
    endfunction

    function longint signed_as(logic [63:0] m, longint ref_v);
      return ref_v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // next position and velocity of the follower for one tick
    function void note_tick(tick_t t);
      longint       d[3], v[3], pos[3], tgt[3];
      longint       des, pull, np;
      logic [127:0] sum;
      logic [63:0]  span, spd, vsq, norm, ms, m, stepm;
      motion_t      r;
      tgt[0] = t.tx; tgt[1] = t.ty; tgt[2] = t.tz;
      pos[0] = t.px; pos[1] = t.py; pos[2] = t.pz;
      ms = {40'd0, max_speed};
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = tgt[i] + longint'(offs[i]) - pos[i];
        m = mag(d[i]);
        sum += {64'd0, m} * {64'd0, m};
        v[i] = longint'(vel[i]);
      end
      if (sum != 0) begin
        span = root(sum);
        spd = (decel == 0) ? ms : (span << 8) / {48'd0, decel};
        if (spd > ms) spd = ms;
        for (int i = 0; i < 3; i++) begin
          des = signed_as(scale(mag(d[i]), spd, span), d[i]);
          pull = des - v[i];
          v[i] += (pull * 2) / 5;
        end
      end
      vsq = '0;
      for (int i = 0; i < 3; i++) vsq += mag(v[i]) * mag(v[i]);
      if (vsq > ms * ms) begin
        norm = root({64'd0, vsq});
        for (int i = 0; i < 3; i++) v[i] = signed_as(scale(mag(v[i]), ms, norm), v[i]);
      end
      for (int i = 0; i < 3; i++) begin
        stepm = (mag(v[i]) * {48'd0, t.dt}) >> 16;
        np = pos[i] + signed_as(stepm, v[i]);
        if (np > 64'sd2147483647) np = 64'sd2147483647;
        if (np < -64'sd2147483648) np = -64'sd2147483648;
        vel[i] = v[i][31:0];
        tgt[i] = np;
      end
      r.nx = tgt[0][31:0]; r.ny = tgt[1][31:0]; r.nz = tgt[2][31:0];
      r.sx = vel[0]; r.sy = vel[1]; r.sz = vel[2];
      pending.push_back(r);
    endfunction

    function void check_result(motion_t got);
      motion_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz ||
          got.sx !== e.sx || got.sy !== e.sy || got.sz !== e.sz) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t: pos exp %0d %0d %0d got %0d %0d %0d, ",
                    "vel exp %0d %0d %0d got %0d %0d %0d"},
                   $realtime, e.nx, e.ny, e.nz, got.nx, got.ny, got.nz,
                   e.sx, e.sy, e.sz, got.sx, got.sy, got.sz);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = REG_MAX_SPEED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  asf_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  asf_out_if #(.COORD_WIDTH(CW)) out_ch ();

  arrive_steering_follower #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  steer_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.target_x = '0; in_ch.target_y = '0; in_ch.target_z = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.step_time = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    motion_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.nx = out_ch.new_x; r.ny = out_ch.new_y; r.nz = out_ch.new_z;
      r.sx = out_ch.speed_x; r.sy = out_ch.speed_y; r.sz = out_ch.speed_z;
      sb.check_result(r);
    end
  end

  task automatic send_tick(tick_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_x <= t.tx; in_ch.target_y <= t.ty; in_ch.target_z <= t.tz;
    in_ch.pos_x <= t.px; in_ch.pos_y <= t.py; in_ch.pos_z <= t.pz;
    in_ch.step_time <= t.dt;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(t);
  endtask

  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_setup(logic [23:0] ms, logic [23:0] dec,
                            logic [23:0] ox, logic [23:0] oy, logic [23:0] oz);
    write_reg(REG_MAX_SPEED, ms);
    write_reg(REG_DECELERATION, dec);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] near(longint aim);
    longint p;
    int     k;
    k = $urandom_range(24);
    p = aim + longint'($signed($urandom_range(2 ** k))) - longint'(2 ** (k - 1 >= 0 ? k - 1 : 0));
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  // mostly a follower chasing a nearby aim point, some wild positions, some exact hits
  function automatic tick_t rand_tick();
    tick_t t;
    int    pick;
    pick = $urandom_range(99);
    t.tx = $urandom; t.ty = $urandom; t.tz = $urandom;
    t.px = $urandom; t.py = $urandom; t.pz = $urandom;
    t.dt = 16'($urandom);
    if (pick < 60) begin
      t.tx = $signed($urandom) >>> $urandom_range(31, 4);
      t.ty = $signed($urandom) >>> $urandom_range(31, 4);
      t.tz = $signed($urandom) >>> $urandom_range(31, 4);
      t.px = near(longint'(t.tx) + longint'(sb.offs[0]));
      t.py = near(longint'(t.ty) + longint'(sb.offs[1]));
      t.pz = near(longint'(t.tz) + longint'(sb.offs[2]));
      if ($urandom_range(3) == 0) t.dt = 16'($urandom_range(2000));
    end else if (pick < 75) begin
      t.px = t.tx + sb.offs[0];
      t.py = t.ty + sb.offs[1];
      t.pz = t.tz + sb.offs[2];
    end
    return t;
  endfunction

  task automatic directed();
    tick_t t;
    logic signed [31:0] ext[4];
    ext[0] = 32'h7fffffff; ext[1] = 32'h80000000; ext[2] = '0; ext[3] = 32'hffffffff;
    // reached aim point, with and without elapsed time
    t.tx = 1000; t.ty = -2000; t.tz = 0;
    t.px = 1000 + sb.offs[0]; t.py = -2000 + sb.offs[1]; t.pz = sb.offs[2];
    t.dt = 0;
    send_tick(t);
    t.dt = 16'hffff;
    send_tick(t);
    for (int i = 0; i < 16; i++) begin
      t.tx = ext[i % 4]; t.ty = ext[(i / 4) % 4]; t.tz = ext[(i + 1) % 4];
      t.px = ext[(i + 2) % 4]; t.py = ext[(i / 2) % 4]; t.pz = ext[(i + 3) % 4];
      t.dt = (i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'd0 : 16'h8000;
      send_tick(t);
    end
    // position saturation with full speed
    t.tx = 32'h7fffffff; t.ty = 32'h80000000; t.tz = 32'h7fffffff;
    t.px = 32'h7fff0000; t.py = 32'h80010000; t.pz = 32'h7fffff00;
    t.dt = 16'hffff;
    send_tick(t);
  endtask

  task automatic run_phase(int n, int mode);
    send_idle_pct  = (mode == 1) ? 77 : (mode == 3) ? 20 : 0;
    recv_stall_pct = (mode == 2) ? 77 : (mode == 3) ? 20 : 0;
    for (int i = 0; i < n; i++) send_tick(rand_tick());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    run_phase(40, 0);
    drain();

    load_setup(24'hffffff, 24'd1, 24'h7fffff, 24'h800000, 24'h000000);
    run_phase(60, 1);
    // receiver goes quiet for a long stretch while beats keep coming
    hold_req <= ~hold_req;
    run_phase(10, 0);
    drain();

    load_setup(24'd0, 24'd65535, 24'($urandom), 24'($urandom), 24'($urandom));
    run_phase(50, 2);
    drain();

    load_setup(24'($urandom), 24'd0, 24'h800000, 24'h7fffff, 24'h7fffff);
    run_phase(60, 3);
    drain();

    load_setup(24'($urandom_range(400000)), 24'($urandom_range(65535, 1)),
               24'($urandom_range(4000) - 2000), 24'($urandom_range(4000) - 2000),
               24'($urandom));
    run_phase(70, 0);
    drain();

    load_setup(24'hffffff, 24'd65535, 24'h000000, 24'h000000, 24'h800000);
    run_phase(60, 1);
    drain();

    load_setup(24'($urandom_range(1000)), 24'($urandom_range(300, 1)),
               24'($urandom), 24'($urandom), 24'($urandom));
    run_phase(60, 2);
    drain();

    load_setup(24'($urandom), 24'($urandom_range(65535, 1)),
               24'($urandom), 24'($urandom), 24'($urandom));
    run_phase(60, 3);
    run_phase(60, 0);
    drain();

    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
